// ----- src/assert_macros.svh -----
// Assertion macros shared by the edge magnitude block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, disabled during reset
`define SEMG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// clocked assertion, checked in every cycle
`define SEMG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ----- src/semg_pkg.sv -----
// Types, constants and helpers of the Sobel edge magnitude block.
// No dependencies.
package semg_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int CFG_W   = 11;
   localparam int PIX_W   = 24;
   localparam int CH_W    = 8;
   localparam int GRAD_W  = 12;
   localparam int SQ_W    = 21;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;
   localparam int STEP_W  = 3;
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;
   localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
   localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
   localparam logic REG_WIDTH_IDX  = 1'b0;
   localparam logic REG_HEIGHT_IDX = 1'b1;
   localparam logic KIND_PIXEL = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_GRAD, ST_SQUARE, ST_ROOT, ST_PUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic grad;
      logic square;
      logic root_step;
      logic [STEP_W-1:0] step;
      logic put;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } stat_type;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int lim);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (32'(v) > lim) r = CFG_W'(lim);
      return r;
   endfunction
endpackage

// ----- src/semg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module semg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/semg_ctrl.sv -----
// Sequencer of the edge magnitude block: fetch, gradient, square, root, put.
// Depends on semg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module semg_ctrl import semg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_FETCH;
         ST_FETCH:  state_in = stat.emit ? ST_GRAD : ST_IDLE;
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: begin
            state_in = ST_ROOT;
            step_in  = '0;
         end
         ST_ROOT: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) state_in = ST_PUT;
         end
         ST_PUT:    if (stat.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.step = step_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_FETCH:  cmd.fetch = 1'b1;
         ST_GRAD:   cmd.grad = 1'b1;
         ST_SQUARE: cmd.square = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_PUT:    cmd.put = stat.out_free;
         default:   cmd = '0;
      endcase
   end

   `SEMG_ASSERT(a_accept_fetch, clock, reset, cmd.accept |=> state_ff == ST_FETCH)
   `SEMG_ASSERT(a_root_put, clock, reset,
      (state_ff == ST_ROOT && step_ff == LAST_STEP) |=> state_ff == ST_PUT)
   `SEMG_ASSERT_ALWAYS(a_put_free, clock, cmd.put |-> stat.out_free)
endmodule

// ----- src/semg_datapath.sv -----
// Datapath: register file, line buffers, window, gradient, square and root.
// Depends on semg_pkg, semg_ram and assert_macros.svh.
`include "assert_macros.svh"
module semg_datapath import semg_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              req_kind,
   input  logic [CH_W-1:0]   req_in_red,
   input  logic [CH_W-1:0]   req_in_green,
   input  logic [CH_W-1:0]   req_in_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CH_W-1:0]   rsp_out_red,
   output logic [CH_W-1:0]   rsp_out_green,
   output logic [CH_W-1:0]   rsp_out_blue,
   output logic              rsp_frame_end,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);
   localparam int CW = $clog2(MAX_WIDTH);

   logic [CFG_W-1:0] wid_ff, wid_in, hgt_ff, hgt_in, uw, uh;
   logic [CW-1:0]    col_ff, col_in;
   logic [CFG_W-1:0] row_ff, row_in, cc_ff, cc_in, cr_ff, cr_in;
   logic [CFG_W:0]   fill_ff, fill_in, fill_lim;
   logic [PIX_W-1:0] pix_ff, pix_in, top_rd, mid_rd;
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic signed [GRAD_W-1:0] gx_ff [3];
   logic signed [GRAD_W-1:0] gy_ff [3];
   logic signed [GRAD_W-1:0] gx_in [3];
   logic signed [GRAD_W-1:0] gy_in [3];
   logic [SQ_W-1:0]  sq_ff [3];
   logic [SQ_W-1:0]  sq_in [3];
   logic [CH_W-1:0]  root_ff [3];
   logic [CH_W-1:0]  root_in [3];
   logic             rsp_valid_ff, rsp_valid_in, end_ff, end_in;
   logic [CH_W-1:0]  red_ff, red_in, grn_ff, grn_in, blu_ff, blu_in;
   logic             cfg_wr, restart, frame_end, col_wrap;
   logic             ok_top, ok_bot, ok_lft, ok_rgt;

   assign uw = clamp_dim(wid_ff, MAX_WIDTH);
   assign uh = clamp_dim(hgt_ff, MAX_HEIGHT);
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_HEIGHT_IDX) ? DATA_W'(hgt_ff) : DATA_W'(wid_ff);
   assign fill_lim = {1'b0, uw} + (CFG_W + 1)'(1);
   assign frame_end = (cr_ff == uh - CFG_W'(1)) && (cc_ff == uw - CFG_W'(1));
   assign restart = cfg_wr || (cmd.put && frame_end);
   assign col_wrap = (32'(col_ff) + 1) >= 32'(uw);

   assign stat.emit = fill_ff >= fill_lim;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign ok_top = cr_ff != '0;
   assign ok_bot = (cr_ff + CFG_W'(1)) < uh;
   assign ok_lft = cc_ff != '0;
   assign ok_rgt = (cc_ff + CFG_W'(1)) < uw;

   semg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .wr_en(cmd.fetch), .wr_addr(col_ff), .wr_data(mid_rd),
      .rd_en(cmd.accept), .rd_addr(col_ff), .rd_data(top_rd));

   semg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .wr_en(cmd.fetch), .wr_addr(col_ff), .wr_data(pix_ff),
      .rd_en(cmd.accept), .rd_addr(col_ff), .rd_data(mid_rd));

   // configuration, positions and window
   always_comb begin
      wid_in  = wid_ff;
      hgt_in  = hgt_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      fill_in = fill_ff;
      cc_in   = cc_ff;
      cr_in   = cr_ff;
      pix_in  = pix_ff;
      win_in  = win_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_WIDTH_IDX) wid_in = pwdata[CFG_W-1:0];
         else hgt_in = pwdata[CFG_W-1:0];
      end
      if (cmd.accept) begin
         pix_in = (req_kind == KIND_PIXEL && row_ff < uh) ?
                  {req_in_red, req_in_green, req_in_blue} : '0;
      end
      if (cmd.fetch) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = top_rd;
         win_in[5] = mid_rd;
         win_in[8] = pix_ff;
         if (!stat.emit) fill_in = fill_ff + (CFG_W + 1)'(1);
         if (col_wrap) begin
            col_in = '0;
            if (row_ff < uh) row_in = row_ff + CFG_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (cmd.put) begin
         if (cc_ff + CFG_W'(1) >= uw) begin
            cc_in = '0;
            cr_in = cr_ff + CFG_W'(1);
         end else begin
            cc_in = cc_ff + CFG_W'(1);
         end
      end
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         fill_in = '0;
         cc_in   = '0;
         cr_in   = '0;
         for (int i = 0; i < 9; i++) win_in[i] = '0;
      end
   end

   // gradient, square and root lanes
   always_comb begin
      logic signed [GRAD_W-1:0] a [9];
      logic signed [2*GRAD_W-1:0] px, py;
      logic [CH_W-1:0] cand;
      logic [2*CH_W-1:0] cq;
      logic ok;
      gx_in   = gx_ff;
      gy_in   = gy_ff;
      sq_in   = sq_ff;
      root_in = root_ff;
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 9; i++) begin
            ok = (i / 3 != 0 || ok_top) && (i / 3 != 2 || ok_bot) &&
                 (i % 3 != 0 || ok_lft) && (i % 3 != 2 || ok_rgt);
            a[i] = ok ? $signed({4'b0, win_ff[i][(2-ch)*CH_W +: CH_W]}) : '0;
         end
         if (cmd.grad) begin
            gx_in[ch] = a[2] - a[0] + ((a[5] - a[3]) <<< 1) + a[8] - a[6];
            gy_in[ch] = a[6] - a[0] + ((a[7] - a[1]) <<< 1) + a[8] - a[2];
         end
         px = gx_ff[ch] * gx_ff[ch];
         py = gy_ff[ch] * gy_ff[ch];
         if (cmd.square) begin
            sq_in[ch]   = px[SQ_W-1:0] + py[SQ_W-1:0];
            root_in[ch] = '0;
         end
         cand = root_ff[ch] | (CH_W'(1) << (LAST_STEP - cmd.step));
         cq = cand * cand - (2*CH_W)'(cand);
         if (cmd.root_step && SQ_W'(cq) < sq_ff[ch]) root_in[ch] = cand;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      red_in = red_ff;
      grn_in = grn_ff;
      blu_in = blu_ff;
      end_in = end_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.put) begin
         rsp_valid_in = 1'b1;
         red_in = root_ff[0];
         grn_in = root_ff[1];
         blu_in = root_ff[2];
         end_in = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff       <= RST_WIDTH;
         hgt_ff       <= RST_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         fill_ff      <= '0;
         cc_ff        <= '0;
         cr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         wid_ff       <= wid_in;
         hgt_ff       <= hgt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         fill_ff      <= fill_in;
         cc_ff        <= cc_in;
         cr_ff        <= cr_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      sq_ff   <= sq_in;
      root_ff <= root_in;
      red_ff  <= red_in;
      grn_ff  <= grn_in;
      blu_ff  <= blu_in;
      end_ff  <= end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = grn_ff;
   assign rsp_out_blue  = blu_ff;
   assign rsp_frame_end = end_ff;

   `SEMG_ASSERT(a_restart_clears, clock, reset,
      restart |=> (row_ff == '0 && fill_ff == '0 && cc_ff == '0 && cr_ff == '0))
   `SEMG_ASSERT(a_put_sets_valid, clock, reset, cmd.put |=> rsp_valid_ff)
   `SEMG_ASSERT(a_centre_in_frame, clock, reset, cmd.put |-> (cr_ff < uh && cc_ff < uw))
endmodule

// ----- src/sobel_edge_magnitude_rgb_unit.sv -----
// Sobel 3x3 edge magnitude on RGB pixels, per channel, with zero border.
// Sequence: a pixel that yields no result returns the block to idle after its fetch; a result
// passes gradient, square, the 8-step root and put, plus any wait for rsp_ready in put.
// One item in flight at a time: a new item is accepted only when the block is idle.
// Reset (synchronous): width 640, height 480, positions and window cleared.
// Depends on semg_pkg, semg_ctrl, semg_datapath and semg_ram.
module sobel_edge_magnitude_rgb_unit import semg_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [CH_W-1:0]   req_in_red,
   input  logic [CH_W-1:0]   req_in_green,
   input  logic [CH_W-1:0]   req_in_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CH_W-1:0]   rsp_out_red,
   output logic [CH_W-1:0]   rsp_out_green,
   output logic [CH_W-1:0]   rsp_out_blue,
   output logic              rsp_frame_end,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);
   cmd_type  cmd;
   stat_type stat;

   semg_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd));

   semg_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_kind), .req_in_red(req_in_red), .req_in_green(req_in_green),
      .req_in_blue(req_in_blue), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_frame_end(rsp_frame_end),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready));
endmodule
